// ===== src/bbr_pkg.sv =====
// ----------------------------------------------------------------------------
// bbr_pkg
// Shared constants and types for the 3x3 RGB box blur core.
// ----------------------------------------------------------------------------
package bbr_pkg;

  localparam int MAX_WIDTH    = 1024;
  localparam int CHANNEL_BITS = 8;
  localparam int ROW_LIMIT    = 4096;

  localparam int NUM_LANES    = 3;
  localparam int NUM_TAPS     = 9;
  localparam int PIX_W        = NUM_LANES * CHANNEL_BITS;
  localparam int COL_W        = $clog2(MAX_WIDTH);
  localparam int ROW_W        = $clog2(ROW_LIMIT);
  localparam int WIDTH_REG_W  = 11;
  localparam int HEIGHT_REG_W = 13;
  localparam int CFG_IDX_W    = 2;
  localparam int CFG_DATA_W   = 13;

  // sum of nine taps, and divide-by-9 as multiply by rounded-up reciprocal
  localparam int SUM_W        = CHANNEL_BITS + 4;
  localparam int DIV_SHIFT    = SUM_W + 3;
  localparam int DIV_MULT     = ((2 ** DIV_SHIFT) + 8) / 9;
  localparam int MULT_W       = DIV_SHIFT - 2;
  localparam int PROD_W       = SUM_W + MULT_W;

  localparam int FIFO_DEPTH   = 16;
  localparam int PTR_W        = $clog2(FIFO_DEPTH);
  localparam int LVL_W        = PTR_W + 1;

  localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_HEIGHT = 2'd1;

  localparam logic [WIDTH_REG_W-1:0]  WIDTH_RESET  = 11'd640;
  localparam logic [HEIGHT_REG_W-1:0] HEIGHT_RESET = 13'd480;

  typedef struct packed {
    logic             blur;
    logic             pass;
    logic [COL_W-1:0] col;
    logic [ROW_W-1:0] row;
    logic [PIX_W-1:0] px;
  } item_t;

  typedef struct packed {
    logic [COL_W-1:0] col;
    logic [ROW_W-1:0] row;
    logic [PIX_W-1:0] px;
    logic             last;
  } result_t;

endpackage

// ===== src/bbr_lane.sv =====
// ----------------------------------------------------------------------------
// bbr_lane
// One color lane: sums the nine window taps, registers the sum, then divides
// by nine with truncation through a reciprocal multiply.
// ----------------------------------------------------------------------------
module bbr_lane (
  input  logic                             clk,
  input  logic [bbr_pkg::CHANNEL_BITS-1:0] taps [bbr_pkg::NUM_TAPS],
  output logic [bbr_pkg::CHANNEL_BITS-1:0] quot
);
  import bbr_pkg::*;

  logic [SUM_W-1:0]  sum;
  logic [SUM_W-1:0]  sum_r;
  logic [PROD_W-1:0] prod;

  always_comb begin
    sum = '0;
    for (int j = 0; j < NUM_TAPS; j++) begin
      sum = sum + SUM_W'(taps[j]);
    end
  end

  always_ff @(posedge clk) begin
    sum_r <= sum;
  end

  assign prod = PROD_W'(sum_r) * PROD_W'(DIV_MULT);
  assign quot = prod[DIV_SHIFT +: CHANNEL_BITS];

endmodule

// ===== src/bbr_merge.sv =====
// ----------------------------------------------------------------------------
// bbr_merge
// Merges the lane quotients with the pass-through pixel into up to two result
// beats per pixel and queues them for the output channel.
// ----------------------------------------------------------------------------
module bbr_merge (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      item_valid,
  input  bbr_pkg::item_t            item,
  input  logic [bbr_pkg::PIX_W-1:0] blurred,
  output logic [bbr_pkg::LVL_W-1:0] level,
  output logic                      out_valid,
  input  logic                      out_stall,
  output logic [bbr_pkg::COL_W-1:0] out_col,
  output logic [bbr_pkg::ROW_W-1:0] out_row,
  output logic [bbr_pkg::CHANNEL_BITS-1:0] out_red_out,
  output logic [bbr_pkg::CHANNEL_BITS-1:0] out_green_out,
  output logic [bbr_pkg::CHANNEL_BITS-1:0] out_blue_out,
  output logic                      out_run_last
);
  import bbr_pkg::*;

  result_t          fifo_r [FIFO_DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [LVL_W-1:0] level_r, level_nxt;
  result_t          blur_res, pass_res, first_res;
  logic [1:0]       n_wr;
  logic             rd;
  result_t          head;

  always_comb begin
    blur_res.col  = item.col - COL_W'(1);
    blur_res.row  = item.row - ROW_W'(1);
    blur_res.px   = blurred;
    blur_res.last = !item.pass;
    pass_res.col  = item.col;
    pass_res.row  = item.row;
    pass_res.px   = item.px;
    pass_res.last = 1'b1;
    first_res     = item.blur ? blur_res : pass_res;
    n_wr          = item_valid ? (2'(item.blur) + 2'(item.pass)) : 2'd0;
  end

  assign rd         = out_valid && !out_stall;
  assign wr_ptr_nxt = wr_ptr_r + PTR_W'(n_wr);
  assign rd_ptr_nxt = rd_ptr_r + PTR_W'(rd);
  assign level_nxt  = level_r + LVL_W'(n_wr) - LVL_W'(rd);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      level_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      level_r  <= level_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (n_wr != 2'd0) begin
      fifo_r[wr_ptr_r] <= first_res;
    end
    if (n_wr == 2'd2) begin
      fifo_r[wr_ptr_r + PTR_W'(1)] <= pass_res;
    end
  end

  assign head          = fifo_r[rd_ptr_r];
  assign level         = level_r;
  assign out_valid     = (level_r != '0);
  assign out_col       = head.col;
  assign out_row       = head.row;
  assign out_red_out   = head.px[0 +: CHANNEL_BITS];
  assign out_green_out = head.px[CHANNEL_BITS +: CHANNEL_BITS];
  assign out_blue_out  = head.px[2*CHANNEL_BITS +: CHANNEL_BITS];
  assign out_run_last  = head.last;

endmodule

// ===== src/box_blur_3x3_rgb_core.sv =====
// ----------------------------------------------------------------------------
// box_blur_3x3_rgb_core
// Streaming 3x3 mean blur over raster-order RGB pixels with border pass-through.
// ----------------------------------------------------------------------------
// Takes one pixel per clock and keeps that rate while the output side takes one
// beat per clock, except in the last row and last column of a frame: there a
// pixel can yield two beats, so once the queue fills the input slows to the
// output rate. A pixel's results pass the s1 and s2 registers, then enter the
// 16-entry result queue; in_stall rises only when that queue could not hold the
// worst case of two results for every pixel in flight and the next one. The two
// source lines sit in one 1024 x 48-bit memory with one read and one write per
// cycle; no clearing pass is needed after reset. The user must write width and
// height through the cfg port only while the core is idle; it is not enforced.
module box_blur_3x3_rgb_core (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [bbr_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [bbr_pkg::CFG_DATA_W-1:0]       cfg_data,
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  logic [bbr_pkg::CHANNEL_BITS-1:0]     in_red_in,
  input  logic [bbr_pkg::CHANNEL_BITS-1:0]     in_green_in,
  input  logic [bbr_pkg::CHANNEL_BITS-1:0]     in_blue_in,
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic [bbr_pkg::COL_W-1:0]            out_col,
  output logic [bbr_pkg::ROW_W-1:0]            out_row,
  output logic [bbr_pkg::CHANNEL_BITS-1:0]     out_red_out,
  output logic [bbr_pkg::CHANNEL_BITS-1:0]     out_green_out,
  output logic [bbr_pkg::CHANNEL_BITS-1:0]     out_blue_out,
  output logic                                 out_run_last
);
  import bbr_pkg::*;

  logic [WIDTH_REG_W-1:0]  width_r;
  logic [HEIGHT_REG_W-1:0] height_r;
  logic [WIDTH_REG_W-1:0]  w_eff;
  logic [HEIGHT_REG_W-1:0] h_eff;

  logic [COL_W-1:0]        col_r, col_nxt;
  logic [ROW_W-1:0]        row_r, row_nxt;
  logic                    col_wrap;
  logic [COL_W-1:0]        c0;
  logic [ROW_W-1:0]        r_inc, r0;
  logic [WIDTH_REG_W-1:0]  c_plus;
  logic [ROW_W-1:0]        r_plus;
  logic                    accept;
  item_t                   item0;

  logic [2*PIX_W-1:0]      line_mem [MAX_WIDTH];
  logic [2*PIX_W-1:0]      rd_r;

  logic                    s1_v_r, s2_v_r;
  item_t                   s1_item_r, s2_item_r;
  logic                    fwd_r;
  logic [PIX_W-1:0]        fwd_top_r, fwd_mid_r;
  logic [PIX_W-1:0]        top_px, mid_px;
  logic [PIX_W-1:0]        win_r [6];

  logic [CHANNEL_BITS-1:0] lane_taps [NUM_LANES][NUM_TAPS];
  logic [CHANNEL_BITS-1:0] lane_q [NUM_LANES];
  logic [PIX_W-1:0]        blurred;
  logic [LVL_W-1:0]        level;
  logic [LVL_W:0]          demand;

  // configuration
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= WIDTH_RESET;
      height_r <= HEIGHT_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_IMAGE_WIDTH:  width_r  <= cfg_data[WIDTH_REG_W-1:0];
        CFG_IMAGE_HEIGHT: height_r <= cfg_data;
        default: ;
      endcase
    end
  end

  always_comb begin
    if (width_r == '0) begin
      w_eff = WIDTH_REG_W'(1);
    end else if (width_r > WIDTH_REG_W'(MAX_WIDTH)) begin
      w_eff = WIDTH_REG_W'(MAX_WIDTH);
    end else begin
      w_eff = width_r;
    end
    if (height_r == '0) begin
      h_eff = HEIGHT_REG_W'(1);
    end else if (height_r > HEIGHT_REG_W'(ROW_LIMIT)) begin
      h_eff = HEIGHT_REG_W'(ROW_LIMIT);
    end else begin
      h_eff = height_r;
    end
  end

  // frame position
  assign accept   = in_valid && !in_stall;
  assign col_wrap = (WIDTH_REG_W'(col_r) >= w_eff);
  assign c0       = col_wrap ? '0 : col_r;
  assign r_inc    = col_wrap ? row_r + ROW_W'(1) : row_r;
  assign r0       = (HEIGHT_REG_W'(r_inc) >= h_eff) ? '0 : r_inc;
  assign c_plus   = WIDTH_REG_W'(c0) + WIDTH_REG_W'(1);
  assign r_plus   = r0 + ROW_W'(1);

  always_comb begin
    col_nxt = c_plus[COL_W-1:0];
    row_nxt = r0;
    if (c_plus >= w_eff) begin
      col_nxt = '0;
      row_nxt = (HEIGHT_REG_W'(r0) + HEIGHT_REG_W'(1) >= h_eff) ? '0 : r_plus;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r <= '0;
      row_r <= '0;
    end else if (accept) begin
      col_r <= col_nxt;
      row_r <= row_nxt;
    end
  end

  always_comb begin
    item0.col  = c0;
    item0.row  = r0;
    item0.px   = {in_blue_in, in_green_in, in_red_in};
    item0.blur = (w_eff >= WIDTH_REG_W'(3)) && (h_eff >= HEIGHT_REG_W'(3))
              && (r0 >= ROW_W'(2)) && (c0 >= COL_W'(2));
    item0.pass = (w_eff < WIDTH_REG_W'(3)) || (h_eff < HEIGHT_REG_W'(3))
              || (r0 == '0) || (HEIGHT_REG_W'(r0) == h_eff - HEIGHT_REG_W'(1))
              || (c0 == '0) || (WIDTH_REG_W'(c0) == w_eff - WIDTH_REG_W'(1));
  end

  // line buffers: {older, newer} per column
  always_ff @(posedge clk) begin
    if (accept) begin
      rd_r <= line_mem[c0];
    end
    if (s1_v_r) begin
      line_mem[s1_item_r.col] <= {mid_px, s1_item_r.px};
    end
  end

  // same-column write in the read cycle (one-pixel-wide frames)
  assign top_px = fwd_r ? fwd_top_r : rd_r[PIX_W +: PIX_W];
  assign mid_px = fwd_r ? fwd_mid_r : rd_r[0 +: PIX_W];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
      s2_v_r <= 1'b0;
    end else begin
      s1_v_r <= accept;
      s2_v_r <= s1_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_item_r <= item0;
      fwd_r     <= s1_v_r && (s1_item_r.col == c0);
      fwd_top_r <= mid_px;
      fwd_mid_r <= s1_item_r.px;
    end
    s2_item_r <= s1_item_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < 6; i++) begin
        win_r[i] <= '0;
      end
    end else if (s1_v_r) begin
      win_r[0] <= win_r[3];
      win_r[1] <= win_r[4];
      win_r[2] <= win_r[5];
      win_r[3] <= top_px;
      win_r[4] <= mid_px;
      win_r[5] <= s1_item_r.px;
    end
  end

  // color lanes
  always_comb begin
    for (int k = 0; k < NUM_LANES; k++) begin
      for (int j = 0; j < 6; j++) begin
        lane_taps[k][j] = win_r[j][k*CHANNEL_BITS +: CHANNEL_BITS];
      end
      lane_taps[k][6] = top_px[k*CHANNEL_BITS +: CHANNEL_BITS];
      lane_taps[k][7] = mid_px[k*CHANNEL_BITS +: CHANNEL_BITS];
      lane_taps[k][8] = s1_item_r.px[k*CHANNEL_BITS +: CHANNEL_BITS];
    end
  end

  for (genvar k = 0; k < NUM_LANES; k++) begin : g_lane
    bbr_lane u_lane (
      .clk  (clk),
      .taps (lane_taps[k]),
      .quot (lane_q[k])
    );
    assign blurred[k*CHANNEL_BITS +: CHANNEL_BITS] = lane_q[k];
  end

  bbr_merge u_merge (
    .clk           (clk),
    .rst_n         (rst_n),
    .item_valid    (s2_v_r),
    .item          (s2_item_r),
    .blurred       (blurred),
    .level         (level),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_col       (out_col),
    .out_row       (out_row),
    .out_red_out   (out_red_out),
    .out_green_out (out_green_out),
    .out_blue_out  (out_blue_out),
    .out_run_last  (out_run_last)
  );

  // room for two beats per pixel in flight plus the next one
  assign demand   = (LVL_W+1)'(level) + (LVL_W+1)'({s1_v_r, 1'b0})
                  + (LVL_W+1)'({s2_v_r, 1'b0}) + (LVL_W+1)'(2);
  assign in_stall = (demand > (LVL_W+1)'(FIFO_DEPTH));

endmodule

// ===== src/bbr_checker.sv =====
// ----------------------------------------------------------------------------
// bbr_checker
// Port-level checks for the box blur core, bound to the top level.
// ----------------------------------------------------------------------------
module bbr_checker (
  input logic                                 clk,
  input logic                                 rst_n,
  input logic                                 in_stall,
  input logic                                 out_valid,
  input logic                                 out_stall,
  input logic [bbr_pkg::COL_W-1:0]            out_col,
  input logic [bbr_pkg::ROW_W-1:0]            out_row,
  input logic [bbr_pkg::CHANNEL_BITS-1:0]     out_red_out,
  input logic [bbr_pkg::CHANNEL_BITS-1:0]     out_green_out,
  input logic [bbr_pkg::CHANNEL_BITS-1:0]     out_blue_out,
  input logic                                 out_run_last
);
  import bbr_pkg::*;

  // a stalled result beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_col) && $stable(out_row)
      && $stable(out_red_out) && $stable(out_green_out) && $stable(out_blue_out)
      && $stable(out_run_last))
    else $error("stalled result beat changed");

  // the second beat of a pixel is queued together with the first
  a_run_follows: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_stall && !out_run_last |=> out_valid)
    else $error("beat without run_last not followed by its partner");

  // empty after reset
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result beat right after reset");

  // an empty core takes input
  a_reset_ready: assert property (@(posedge clk)
    !rst_n |=> !in_stall)
    else $error("input stalled right after reset");

endmodule

bind box_blur_3x3_rgb_core bbr_checker u_bbr_checker (.*);

// ===== verif/box_blur_3x3_rgb_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// box_blur_3x3_rgb_checker
// Tracks the size registers and the pixel stream, predicts the blurred and
// passed-through pixels of every input beat, and compares each result beat
// field by field with the oldest prediction.
// ----------------------------------------------------------------------------
module box_blur_3x3_rgb_checker (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 cfg_valid,
  input  logic                                 cfg_ready,
  input  logic [bbr_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [bbr_pkg::CFG_DATA_W-1:0]       cfg_data,
  input  logic                                 in_valid,
  input  logic                                 in_stall,
  input  logic [bbr_pkg::CHANNEL_BITS-1:0]     in_red_in,
  input  logic [bbr_pkg::CHANNEL_BITS-1:0]     in_green_in,
  input  logic [bbr_pkg::CHANNEL_BITS-1:0]     in_blue_in,
  input  logic                                 out_valid,
  input  logic                                 out_stall,
  input  logic [bbr_pkg::COL_W-1:0]            out_col,
  input  logic [bbr_pkg::ROW_W-1:0]            out_row,
  input  logic [bbr_pkg::CHANNEL_BITS-1:0]     out_red_out,
  input  logic [bbr_pkg::CHANNEL_BITS-1:0]     out_green_out,
  input  logic [bbr_pkg::CHANNEL_BITS-1:0]     out_blue_out,
  input  logic                                 out_run_last,
  output int                                   errors,
  output int                                   pending
);
  import bbr_pkg::*;

  localparam int CB = CHANNEL_BITS;

  logic [PIX_W-1:0]        older_line [MAX_WIDTH];
  logic [PIX_W-1:0]        newer_line [MAX_WIDTH];
  logic [PIX_W-1:0]        window [6];
  logic [WIDTH_REG_W-1:0]  width_reg;
  logic [HEIGHT_REG_W-1:0] height_reg;
  int                      col_pos;
  int                      row_pos;
  int                      err_count;
  result_t                 expected_pixels [$];

  assign errors = err_count;

  task automatic predict_pixel(input logic [PIX_W-1:0] px);
    int w, h, c, r, k, j, sum;
    logic [PIX_W-1:0] top, mid, avg;
    logic [PIX_W-1:0] taps [9];
    logic inner, on_border;
    result_t res;
    w = int'(width_reg);
    if (w == 0) w = 1;
    if (w > MAX_WIDTH) w = MAX_WIDTH;
    h = int'(height_reg);
    if (h == 0) h = 1;
    if (h > ROW_LIMIT) h = ROW_LIMIT;
    // size cut in mid-frame
    if (col_pos >= w) begin
      col_pos = 0;
      row_pos++;
    end
    if (row_pos >= h) row_pos = 0;
    c = col_pos;
    r = row_pos;
    top = older_line[c];
    mid = newer_line[c];
    taps[0] = top;
    taps[1] = mid;
    taps[2] = px;
    for (j = 0; j < 6; j++) taps[3 + j] = window[j];
    for (k = 0; k < NUM_LANES; k++) begin
      sum = 0;
      for (j = 0; j < NUM_TAPS; j++) sum += int'(taps[j][k*CB +: CB]);
      avg[k*CB +: CB] = CB'(sum / NUM_TAPS);
    end
    inner = (w >= 3 && h >= 3 && r >= 2 && c >= 2);
    on_border = (w < 3 || h < 3 || r == 0 || r == h - 1 || c == 0 || c == w - 1);
    if (inner) begin
      res.col = COL_W'(c - 1);
      res.row = ROW_W'(r - 1);
      res.px = avg;
      res.last = ~on_border;
      expected_pixels.push_back(res);
    end
    if (on_border) begin
      res.col = COL_W'(c);
      res.row = ROW_W'(r);
      res.px = px;
      res.last = 1'b1;
      expected_pixels.push_back(res);
    end
    for (j = 0; j < 3; j++) window[j] = window[j + 3];
    window[3] = top;
    window[4] = mid;
    window[5] = px;
    older_line[c] = mid;
    newer_line[c] = px;
    col_pos = c + 1;
    if (col_pos >= w) begin
      col_pos = 0;
      row_pos = r + 1;
      if (row_pos >= h) row_pos = 0;
    end
  endtask

  task automatic check_field(input string what, input int want, input int got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, what, want, got);
      err_count++;
    end
  endtask

  task automatic check_result();
    result_t want;
    if (expected_pixels.size() == 0) begin
      $display("%0t: result beat (col %0d, row %0d) with nothing expected",
               $time, out_col, out_row);
      err_count++;
    end else begin
      want = expected_pixels.pop_front();
      check_field("col", int'(want.col), int'(out_col));
      check_field("row", int'(want.row), int'(out_row));
      check_field("red", int'(want.px[0 +: CB]), int'(out_red_out));
      check_field("green", int'(want.px[CB +: CB]), int'(out_green_out));
      check_field("blue", int'(want.px[2*CB +: CB]), int'(out_blue_out));
      check_field("run_last", int'(want.last), int'(out_run_last));
    end
  endtask

  initial err_count = 0;

  always @(posedge clk) begin
    int i;
    if (!rst_n) begin
      width_reg = WIDTH_RESET;
      height_reg = HEIGHT_RESET;
      col_pos = 0;
      row_pos = 0;
      for (i = 0; i < 6; i++) window[i] = '0;
      for (i = 0; i < MAX_WIDTH; i++) begin
        older_line[i] = '0;
        newer_line[i] = '0;
      end
      expected_pixels.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_IMAGE_WIDTH: width_reg = cfg_data[WIDTH_REG_W-1:0];
          CFG_IMAGE_HEIGHT: height_reg = cfg_data[HEIGHT_REG_W-1:0];
          default: ;
        endcase
      end
      if (in_valid && !in_stall) predict_pixel({in_blue_in, in_green_in, in_red_in});
      if (out_valid && !out_stall) check_result();
    end
    pending <= expected_pixels.size();
  end

endmodule

// ===== verif/tb_box_blur_3x3_rgb_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_box_blur_3x3_rgb_core
// Drives raster-order RGB frames of many sizes into the box blur core, with
// mid-frame size cuts, out-of-range sizes, random gaps and stalls on both
// sides and one long output hold-off; a checker beside the core predicts and
// compares every result beat.
// ----------------------------------------------------------------------------
module tb_box_blur_3x3_rgb_core;
  import bbr_pkg::*;

  localparam int HOLD_CYCLES    = 300;
  localparam int WATCHDOG_LIMIT = 3000;
  localparam int SETTLE_CYCLES  = 12;
  localparam int PHASE_PIXELS   = 460;

  logic                    clk;
  logic                    rst_n;
  logic                    cfg_valid;
  logic                    cfg_ready;
  logic [CFG_IDX_W-1:0]    cfg_index;
  logic [CFG_DATA_W-1:0]   cfg_data;
  logic                    in_valid;
  logic                    in_stall;
  logic [CHANNEL_BITS-1:0] in_red_in;
  logic [CHANNEL_BITS-1:0] in_green_in;
  logic [CHANNEL_BITS-1:0] in_blue_in;
  logic                    out_valid;
  logic                    out_stall;
  logic [COL_W-1:0]        out_col;
  logic [ROW_W-1:0]        out_row;
  logic [CHANNEL_BITS-1:0] out_red_out;
  logic [CHANNEL_BITS-1:0] out_green_out;
  logic [CHANNEL_BITS-1:0] out_blue_out;
  logic                    out_run_last;
  int                      errors;
  int                      pending;

  int tx_gap_pct;
  int rx_stall_pct;
  bit pressure_on;
  int quiet_cycles = 0;

  box_blur_3x3_rgb_core dut (.*);

  box_blur_3x3_rgb_checker u_checker (.*);

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // result side: random stalls, plus one long hold-off to back the core up
  initial begin
    bit held;
    held = 1'b0;
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (pressure_on && !held) begin
        held = 1'b1;
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(negedge clk);
      end
      out_stall <= ($urandom_range(0, 99) < rx_stall_pct);
    end
  end

  function automatic logic [CHANNEL_BITS-1:0] pick_channel();
    if ($urandom_range(0, 7) == 0) return $urandom_range(0, 1) ? '1 : '0;
    return CHANNEL_BITS'($urandom_range(0, 255));
  endfunction

  task automatic send_pixel(input logic [CHANNEL_BITS-1:0] red,
                            input logic [CHANNEL_BITS-1:0] green,
                            input logic [CHANNEL_BITS-1:0] blue);
    @(negedge clk);
    while ($urandom_range(0, 99) < tx_gap_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_red_in <= red;
    in_green_in <= green;
    in_blue_in <= blue;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  task automatic send_random_pixel();
    send_pixel(pick_channel(), pick_channel(), pick_channel());
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] index, input int value);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= index;
    cfg_data <= CFG_DATA_W'(value);
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic set_size(input int w, input int h);
    write_reg(CFG_IMAGE_WIDTH, w);
    write_reg(CFG_IMAGE_HEIGHT, h);
  endtask

  // wait for the core to go idle: all results in, pixels with no result flushed
  task automatic drain();
    @(negedge clk);
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic run_phase(input int tx, input int rx, input int goal);
    int sent, w, h, frames;
    tx_gap_pct = tx;
    rx_stall_pct = rx;
    sent = 0;
    while (sent < goal) begin
      case ($urandom_range(0, 9))
        0: begin
          w = $urandom_range(1, 2);
          h = $urandom_range(1, 6);
        end
        1: begin
          w = $urandom_range(3, 12);
          h = $urandom_range(1, 2);
        end
        2: begin
          w = $urandom_range(24, 48);
          h = $urandom_range(3, 5);
        end
        default: begin
          w = $urandom_range(3, 16);
          h = $urandom_range(3, 10);
        end
      endcase
      frames = $urandom_range(1, 2);
      drain();
      set_size(w, h);
      repeat (w * h * frames) send_random_pixel();
      sent += w * h * frames;
    end
  endtask

  initial begin
    rst_n = 1'b0;
    cfg_valid = 1'b0;
    cfg_index = CFG_IMAGE_WIDTH;
    cfg_data = '0;
    in_valid = 1'b0;
    in_red_in = '0;
    in_green_in = '0;
    in_blue_in = '0;
    tx_gap_pct = 13;
    rx_stall_pct = 56;
    pressure_on = 1'b0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // reset size, part of row 0, then cut width to 3 in mid-row
    send_pixel(8'hFF, 8'h00, 8'h00);
    send_pixel(8'hFF, 8'h00, 8'hFF);
    send_pixel(8'hFF, 8'h00, 8'h80);
    send_pixel(8'h00, 8'hFF, 8'h7F);
    drain();
    set_size(3, 3);
    send_pixel(8'hFF, 8'h00, 8'h01);
    send_pixel(8'hFF, 8'h00, 8'hFE);
    send_pixel(8'hFF, 8'h00, 8'h10);
    send_pixel(8'hFF, 8'h00, 8'h33);
    send_pixel(8'hFF, 8'h00, 8'hC4);
    send_pixel(8'hFF, 8'h00, 8'h08);

    // zero sizes act as 1
    drain();
    set_size(0, 0);
    send_pixel(8'h12, 8'hED, 8'h5A);
    send_pixel(8'hED, 8'h12, 8'hA5);

    // height saturates, then is cut below the current row
    drain();
    set_size(2, 8191);
    repeat (4) send_random_pixel();
    drain();
    write_reg(CFG_IMAGE_HEIGHT, 1);
    repeat (2) send_random_pixel();

    // width saturates, then is cut in mid-row
    drain();
    set_size(8191, 3);
    repeat (3) send_random_pixel();
    drain();
    write_reg(CFG_IMAGE_WIDTH, 3);
    repeat (6) send_random_pixel();

    run_phase(13, 56, PHASE_PIXELS);
    run_phase(56, 13, PHASE_PIXELS);

    tx_gap_pct = 0;
    rx_stall_pct = 0;
    drain();
    set_size(20, 12);
    pressure_on = 1'b1;
    repeat (240) send_random_pixel();
    run_phase(0, 0, PHASE_PIXELS - 240);

    drain();
    if (errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
